### rtl/point_rotate_about_center_macros.svh
// ----------------------------------------------------------------------------
// point rotate assertion macros
// concurrent check shorthands on clk with synchronous reset rst
// ----------------------------------------------------------------------------
`ifndef POINT_ROTATE_ABOUT_CENTER_MACROS_SVH
`define POINT_ROTATE_ABOUT_CENTER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PRCA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("prca check failed");
// next-cycle implication
`define PRCA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("prca check failed");
`else
`define PRCA_ASSERT_NOW(label, ante, cons)
`define PRCA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### rtl/prca_pkg.sv
// ----------------------------------------------------------------------------
// prca_pkg
// shared widths, constants, tables and types of the point rotation pipeline
// ----------------------------------------------------------------------------
package prca_pkg;

  localparam int COORD_BITS    = 24;
  localparam int CORDIC_STAGES = 18;
  localparam int FRAC_BITS     = 16;
  localparam int ANGLE_BITS    = 16;
  localparam int DW            = COORD_BITS + 1;          // offset width
  localparam int ALT_W         = COORD_BITS + 2;          // exact-path result width
  localparam int CW            = COORD_BITS + FRAC_BITS + 4; // cordic x/y width
  localparam int ZW            = 32;                      // angle residual width
  localparam int RW            = CW - FRAC_BITS;          // rounded width
  localparam int WW            = RW + 2;                  // final sum width
  localparam int PW            = DW + 31;                 // gain product width
  localparam int K_SHIFT       = 30 - FRAC_BITS;
  localparam int STAGE_BITS    = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DW        = (COORD_BITS > ANGLE_BITS) ? COORD_BITS : ANGLE_BITS;

  localparam longint COORD_HI = (longint'(1) <<< (COORD_BITS - 1)) - 1;
  localparam longint COORD_LO = -(longint'(1) <<< (COORD_BITS - 1));

  // cordic gain compensation in q30
  localparam logic signed [30:0] K_Q30 = 31'sd652032874;
  localparam logic [ANGLE_BITS-1:0] QUARTER = 16'h4000;

  typedef logic signed [COORD_BITS-1:0] prca_coord_t;
  typedef logic signed [DW-1:0]         prca_dw_t;
  typedef logic signed [ALT_W-1:0]      prca_alt_t;
  typedef logic signed [CW-1:0]         prca_cw_t;
  typedef logic signed [ZW-1:0]         prca_zw_t;
  typedef logic signed [RW-1:0]         prca_rw_t;
  typedef logic signed [WW-1:0]         prca_ww_t;
  typedef logic signed [PW-1:0]         prca_pw_t;
  typedef logic [STAGE_BITS-1:0]        prca_stage_t;

  localparam prca_cw_t ROUND_HALF = prca_cw_t'(longint'(1) <<< (FRAC_BITS - 1));

  // arctangent of 2^-i in 2^-32 turn
  localparam logic [31:0] ATAN_TAB [0:31] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X    = 3'd0,
    CFG_CENTER_Y    = 3'd1,
    CFG_ANGLE_TURNS = 3'd2,
    CFG_CLOCKWISE   = 3'd3
  } prca_cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_CENTER  = 2'd0,
    MODE_QUARTER = 2'd1,
    MODE_CORDIC  = 2'd2
  } prca_mode_t;

  typedef struct packed {
    prca_coord_t point_x;
    prca_coord_t point_y;
  } prca_in_t;

  typedef struct packed {
    prca_coord_t rotated_x;
    prca_coord_t rotated_y;
    logic        saturated;
  } prca_out_t;

  typedef struct packed {
    prca_coord_t           center_x;
    prca_coord_t           center_y;
    logic [ANGLE_BITS-1:0] angle_turns;
    logic                  clockwise;
  } prca_cfg_t;

  // data that rides alongside the cordic values
  typedef struct packed {
    prca_mode_t mode;
    prca_alt_t  alt_x;
    prca_alt_t  alt_y;
  } prca_side_t;

  typedef struct packed {
    prca_cw_t   x;
    prca_cw_t   y;
    prca_zw_t   z;
    prca_side_t side;
  } prca_cell_t;

endpackage

### rtl/point_rotate_about_center.sv
// registered path: pre stages 1, 2 and 3, each cordic cell, then post stages a and b
// throughput: one point per cycle unless out_ready stalls, one cordic cell per stage
// every stage has its own register, so a stalled result does not block bubbles upstream
// reset clears all valid flags and loads center 0, angle a quarter turn, clockwise
// ----------------------------------------------------------------------------
// point_rotate_about_center
// rotates streamed points about a configured center, exact quarter turn or cordic
// ----------------------------------------------------------------------------
module point_rotate_about_center (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [prca_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [prca_pkg::CFG_DW-1:0]       cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  prca_pkg::prca_in_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output prca_pkg::prca_out_t               out_data
);

  localparam int N = prca_pkg::CORDIC_STAGES;

  prca_pkg::prca_cfg_t  cfg;
  logic [N:0]           chain_valid;
  logic [N:0]           chain_ready;
  prca_pkg::prca_cell_t chain_data [0:N];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_x    <= '0;
      cfg.center_y    <= '0;
      cfg.angle_turns <= prca_pkg::QUARTER;
      cfg.clockwise   <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        prca_pkg::CFG_CENTER_X:    cfg.center_x    <= cfg_data[prca_pkg::COORD_BITS-1:0];
        prca_pkg::CFG_CENTER_Y:    cfg.center_y    <= cfg_data[prca_pkg::COORD_BITS-1:0];
        prca_pkg::CFG_ANGLE_TURNS: cfg.angle_turns <= cfg_data[prca_pkg::ANGLE_BITS-1:0];
        prca_pkg::CFG_CLOCKWISE:   cfg.clockwise   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  prca_pre u_pre (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (chain_valid[0]),
    .out_ready (chain_ready[0]),
    .out_data  (chain_data[0])
  );

  for (genvar i = 0; i < N; i++) begin : g_cell
    prca_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .stage     (prca_pkg::prca_stage_t'(i)),
      .in_valid  (chain_valid[i]),
      .in_ready  (chain_ready[i]),
      .in_data   (chain_data[i]),
      .out_valid (chain_valid[i+1]),
      .out_ready (chain_ready[i+1]),
      .out_data  (chain_data[i+1])
    );
  end

  prca_post u_post (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (chain_valid[N]),
    .in_ready  (chain_ready[N]),
    .in_data   (chain_data[N]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### rtl/prca_pre.sv
// ----------------------------------------------------------------------------
// prca_pre
// offsets, gain compensation, exact paths and quadrant fold ahead of the cells
// ----------------------------------------------------------------------------
`include "point_rotate_about_center_macros.svh"

module prca_pre (
  input  logic                 clk,
  input  logic                 rst,
  input  prca_pkg::prca_cfg_t  cfg,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  prca_pkg::prca_in_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output prca_pkg::prca_cell_t out_data
);

  localparam logic [1:0] QUAD_0   = 2'd0;
  localparam logic [1:0] QUAD_90  = 2'd1;
  localparam logic [1:0] QUAD_180 = 2'd2;
  localparam logic [1:0] QUAD_270 = 2'd3;

  localparam prca_pkg::prca_pw_t K_Q30_EXT = prca_pkg::prca_pw_t'(prca_pkg::K_Q30);

  // stage 1: offsets and path select
  logic                  s1_valid;
  logic                  s1_ready;
  prca_pkg::prca_dw_t    s1_dx;
  prca_pkg::prca_dw_t    s1_dy;
  prca_pkg::prca_coord_t s1_px;
  prca_pkg::prca_coord_t s1_py;
  prca_pkg::prca_mode_t  s1_mode;
  prca_pkg::prca_dw_t    dx_next;
  prca_pkg::prca_dw_t    dy_next;
  prca_pkg::prca_mode_t  mode_next;

  // stage 2: gain product and exact results
  logic                  s2_valid;
  logic                  s2_ready;
  prca_pkg::prca_cw_t    s2_x;
  prca_pkg::prca_cw_t    s2_y;
  prca_pkg::prca_side_t  s2_side;
  prca_pkg::prca_pw_t    prod_x;
  prca_pkg::prca_pw_t    prod_y;
  prca_pkg::prca_side_t  side_next;

  // stage 3: quadrant fold, feeds the first cell
  logic                  s3_ready;
  logic [31:0]           a32;
  logic [31:0]           phi;
  logic [31:0]           phi_bias;
  logic [1:0]            quad;
  logic [31:0]           res;
  prca_pkg::prca_cw_t    x_fold;
  prca_pkg::prca_cw_t    y_fold;

  assign s1_ready = !s1_valid || s2_ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign s3_ready = !out_valid || out_ready;
  assign in_ready = s1_ready;

  assign dx_next = prca_pkg::prca_dw_t'(in_data.point_x) - prca_pkg::prca_dw_t'(cfg.center_x);
  assign dy_next = prca_pkg::prca_dw_t'(cfg.center_y) - prca_pkg::prca_dw_t'(in_data.point_y);

  always_comb begin
    if (dx_next == '0 && dy_next == '0) begin
      mode_next = prca_pkg::MODE_CENTER;
    end else if (cfg.angle_turns == prca_pkg::QUARTER) begin
      mode_next = prca_pkg::MODE_QUARTER;
    end else begin
      mode_next = prca_pkg::MODE_CORDIC;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s1_ready) begin
      s1_dx   <= dx_next;
      s1_dy   <= dy_next;
      s1_px   <= in_data.point_x;
      s1_py   <= in_data.point_y;
      s1_mode <= mode_next;
    end
  end

  assign prod_x = s1_dx * K_Q30_EXT;
  assign prod_y = s1_dy * K_Q30_EXT;

  always_comb begin
    side_next.mode = s1_mode;
    if (s1_mode == prca_pkg::MODE_CENTER) begin
      side_next.alt_x = prca_pkg::prca_alt_t'(s1_px);
      side_next.alt_y = prca_pkg::prca_alt_t'(s1_py);
    end else if (cfg.clockwise) begin
      side_next.alt_x = prca_pkg::prca_alt_t'(cfg.center_x) + prca_pkg::prca_alt_t'(s1_dy);
      side_next.alt_y = prca_pkg::prca_alt_t'(cfg.center_y) + prca_pkg::prca_alt_t'(s1_dx);
    end else begin
      side_next.alt_x = prca_pkg::prca_alt_t'(cfg.center_x) - prca_pkg::prca_alt_t'(s1_dy);
      side_next.alt_y = prca_pkg::prca_alt_t'(cfg.center_y) - prca_pkg::prca_alt_t'(s1_dx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s2_ready) begin
      s2_x    <= prca_pkg::prca_cw_t'(prod_x >>> prca_pkg::K_SHIFT);
      s2_y    <= prca_pkg::prca_cw_t'(prod_y >>> prca_pkg::K_SHIFT);
      s2_side <= side_next;
    end
  end

  // nearest quarter turn taken out exactly, residual in [-1/8, 1/8) turn
  assign a32      = {cfg.angle_turns, 16'h0000};
  assign phi      = cfg.clockwise ? (32'h0000_0000 - a32) : a32;
  assign phi_bias = phi + 32'h2000_0000;
  assign quad     = phi_bias[31:30];
  assign res      = phi - {quad, 30'h0000_0000};

  always_comb begin
    case (quad)
      QUAD_0: begin
        x_fold = s2_x;
        y_fold = s2_y;
      end
      QUAD_90: begin
        x_fold = -s2_y;
        y_fold = s2_x;
      end
      QUAD_180: begin
        x_fold = -s2_x;
        y_fold = -s2_y;
      end
      QUAD_270: begin
        x_fold = s2_y;
        y_fold = -s2_x;
      end
      default: begin
        x_fold = s2_x;
        y_fold = s2_y;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s3_ready) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid && s3_ready) begin
      out_data.x    <= x_fold;
      out_data.y    <= y_fold;
      out_data.z    <= prca_pkg::prca_zw_t'(res);
      out_data.side <= s2_side;
    end
  end

  `PRCA_ASSERT_NEXT(a_accept_loads, in_valid && in_ready, s1_valid)
  `PRCA_ASSERT_NOW(a_center_zero, s1_valid && s1_mode == prca_pkg::MODE_CENTER, s1_dx == '0 && s1_dy == '0)
  `PRCA_ASSERT_NEXT(a_s2_holds, s2_valid && !s3_ready, s2_valid && $stable(s2_x) && $stable(s2_y))

endmodule

### rtl/prca_cell.sv
// ----------------------------------------------------------------------------
// prca_cell
// one cordic micro-rotation stage with its own handshake register
// ----------------------------------------------------------------------------
module prca_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  prca_pkg::prca_stage_t stage,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  prca_pkg::prca_cell_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output prca_pkg::prca_cell_t  out_data
);

  prca_pkg::prca_cw_t   xs;
  prca_pkg::prca_cw_t   ys;
  prca_pkg::prca_zw_t   at;
  prca_pkg::prca_cell_t step_next;

  assign in_ready = !out_valid || out_ready;

  assign xs = in_data.x >>> stage;
  assign ys = in_data.y >>> stage;
  assign at = prca_pkg::prca_zw_t'(prca_pkg::ATAN_TAB[stage]);

  always_comb begin
    step_next.side = in_data.side;
    // rotate toward zero residual
    if (!in_data.z[prca_pkg::ZW-1]) begin
      step_next.x = in_data.x - ys;
      step_next.y = in_data.y + xs;
      step_next.z = in_data.z - at;
    end else begin
      step_next.x = in_data.x + ys;
      step_next.y = in_data.y - xs;
      step_next.z = in_data.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= step_next;
    end
  end

endmodule

### rtl/prca_post.sv
// ----------------------------------------------------------------------------
// prca_post
// rounding, re-centering, saturation and the result register
// ----------------------------------------------------------------------------
`include "point_rotate_about_center_macros.svh"

module prca_post (
  input  logic                 clk,
  input  logic                 rst,
  input  prca_pkg::prca_cfg_t  cfg,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  prca_pkg::prca_cell_t in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output prca_pkg::prca_out_t  out_data
);

  localparam prca_pkg::prca_ww_t HI = prca_pkg::prca_ww_t'(prca_pkg::COORD_HI);
  localparam prca_pkg::prca_ww_t LO = prca_pkg::prca_ww_t'(prca_pkg::COORD_LO);

  // stage a: rounded cordic results
  logic                 a_valid;
  logic                 a_ready;
  prca_pkg::prca_rw_t   a_rx;
  prca_pkg::prca_rw_t   a_ry;
  prca_pkg::prca_side_t a_side;
  prca_pkg::prca_cw_t   x_adj;
  prca_pkg::prca_cw_t   y_adj;

  // stage b: result register
  logic                 b_ready;
  prca_pkg::prca_mode_t b_mode;
  prca_pkg::prca_ww_t   ox_w;
  prca_pkg::prca_ww_t   oy_w;
  logic                 x_hi;
  logic                 x_lo;
  logic                 y_hi;
  logic                 y_lo;
  prca_pkg::prca_out_t  res_next;

  assign a_ready  = !a_valid || b_ready;
  assign b_ready  = !out_valid || out_ready;
  assign in_ready = a_ready;

  // halves away from zero: negative values take one less of bias before floor
  assign x_adj = in_data.x + (in_data.x[prca_pkg::CW-1] ?
                              (prca_pkg::ROUND_HALF - prca_pkg::prca_cw_t'(1)) :
                              prca_pkg::ROUND_HALF);
  assign y_adj = in_data.y + (in_data.y[prca_pkg::CW-1] ?
                              (prca_pkg::ROUND_HALF - prca_pkg::prca_cw_t'(1)) :
                              prca_pkg::ROUND_HALF);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && a_ready) begin
      a_rx   <= prca_pkg::prca_rw_t'(x_adj >>> prca_pkg::FRAC_BITS);
      a_ry   <= prca_pkg::prca_rw_t'(y_adj >>> prca_pkg::FRAC_BITS);
      a_side <= in_data.side;
    end
  end

  always_comb begin
    if (a_side.mode == prca_pkg::MODE_CORDIC) begin
      ox_w = prca_pkg::prca_ww_t'(cfg.center_x) + prca_pkg::prca_ww_t'(a_rx);
      oy_w = prca_pkg::prca_ww_t'(cfg.center_y) - prca_pkg::prca_ww_t'(a_ry);
    end else begin
      ox_w = prca_pkg::prca_ww_t'(a_side.alt_x);
      oy_w = prca_pkg::prca_ww_t'(a_side.alt_y);
    end
  end

  assign x_hi = ox_w > HI;
  assign x_lo = ox_w < LO;
  assign y_hi = oy_w > HI;
  assign y_lo = oy_w < LO;

  always_comb begin
    res_next.rotated_x = x_hi ? prca_pkg::prca_coord_t'(HI) :
                         x_lo ? prca_pkg::prca_coord_t'(LO) : prca_pkg::prca_coord_t'(ox_w);
    res_next.rotated_y = y_hi ? prca_pkg::prca_coord_t'(HI) :
                         y_lo ? prca_pkg::prca_coord_t'(LO) : prca_pkg::prca_coord_t'(oy_w);
    res_next.saturated = x_hi || x_lo || y_hi || y_lo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_ready) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid && b_ready) begin
      out_data <= res_next;
      b_mode   <= a_side.mode;
    end
  end

  `PRCA_ASSERT_NEXT(a_a_to_b, a_valid && b_ready, out_valid)
  `PRCA_ASSERT_NOW(a_center_no_sat, out_valid && b_mode == prca_pkg::MODE_CENTER, !out_data.saturated)
  `PRCA_ASSERT_NEXT(a_a_holds, a_valid && !b_ready, a_valid && $stable(a_rx) && $stable(a_ry))

endmodule

### tb/sv/point_rotate_checker.sv
// ----------------------------------------------------------------------------
// point_rotate_checker
// watches the register port and both streams of the point rotator, predicts
// each rotated point from its own copy of the settings and checks results in order
// ----------------------------------------------------------------------------
module point_rotate_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [prca_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [prca_pkg::CFG_DW-1:0]    cfg_data,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  prca_pkg::prca_in_t             in_data,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  prca_pkg::prca_out_t            out_data,
  output int                             mismatch_count,
  output int                             points_pending
);

  localparam longint GAIN_Q30   = 652032874;
  localparam int     GAIN_SHIFT = 14;       // q30 product down to 16 fraction bits
  localparam int     FRACTION   = 16;
  localparam longint COORD_MAX  = (longint'(1) <<< (prca_pkg::COORD_BITS - 1)) - 1;
  localparam longint COORD_MIN  = -(longint'(1) <<< (prca_pkg::COORD_BITS - 1));

  // arctan(2^-i) in 2^-32 turn
  localparam logic [31:0] ARCTAN_STEP [0:31] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  prca_pkg::prca_cfg_t regs;
  prca_pkg::prca_out_t expected_points [$];
  prca_pkg::prca_out_t want;

  function automatic longint round_half_away(input longint v);
    longint half;
    half = longint'(1) <<< (FRACTION - 1);
    if (v >= 0) return (v + half) >>> FRACTION;
    return -((-v + half) >>> FRACTION);
  endfunction

  function automatic longint clamp_coord(input longint v);
    if (v > COORD_MAX) return COORD_MAX;
    if (v < COORD_MIN) return COORD_MIN;
    return v;
  endfunction

  function automatic prca_pkg::prca_out_t predict_rotation(input prca_pkg::prca_cfg_t c,
                                                           input prca_pkg::prca_in_t p);
    longint    px, py, cx, cy, dx, dy, ox, oy, x, y, z, t, xs, ys;
    logic [31:0] a32, phi, q, res;
    prca_pkg::prca_out_t r;
    px = longint'(p.point_x);
    py = longint'(p.point_y);
    cx = longint'(c.center_x);
    cy = longint'(c.center_y);
    // offsets with y pointing up
    dx = px - cx;
    dy = cy - py;
    if (dx == 0 && dy == 0) begin
      ox = px;
      oy = py;
    end else if (c.angle_turns == prca_pkg::QUARTER) begin
      if (c.clockwise) begin
        ox = cx + dy;
        oy = cy + dx;
      end else begin
        ox = cx - dy;
        oy = cy - dx;
      end
    end else begin
      a32 = {c.angle_turns, 16'h0000};
      phi = c.clockwise ? (32'd0 - a32) : a32;
      // nearest whole quarter turn, residual in [-1/8, 1/8) turn
      q   = (phi + 32'h2000_0000) >> 30;
      res = phi - (q << 30);
      z   = longint'($signed(res));
      x   = (dx * GAIN_Q30) >>> GAIN_SHIFT;
      y   = (dy * GAIN_Q30) >>> GAIN_SHIFT;
      case (q[1:0])
        2'd1: begin
          t = x;
          x = -y;
          y = t;
        end
        2'd2: begin
          x = -x;
          y = -y;
        end
        2'd3: begin
          t = x;
          x = y;
          y = -t;
        end
        default: ;
      endcase
      for (int i = 0; i < prca_pkg::CORDIC_STAGES; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x = x - ys;
          y = y + xs;
          z = z - longint'(ARCTAN_STEP[i]);
        end else begin
          x = x + ys;
          y = y - xs;
          z = z + longint'(ARCTAN_STEP[i]);
        end
      end
      ox = cx + round_half_away(x);
      oy = cy - round_half_away(y);
    end
    r.saturated = (clamp_coord(ox) != ox) || (clamp_coord(oy) != oy);
    r.rotated_x = prca_pkg::prca_coord_t'(clamp_coord(ox));
    r.rotated_y = prca_pkg::prca_coord_t'(clamp_coord(oy));
    return r;
  endfunction

  task automatic report_mismatch(input string detail);
    $display("[%0t] point check: %s", $time, detail);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      regs.center_x    = '0;
      regs.center_y    = '0;
      regs.angle_turns = prca_pkg::QUARTER;
      regs.clockwise   = 1'b1;
      expected_points.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_points.size() == 0) begin
          report_mismatch($sformatf("result (%0d, %0d) with nothing expected",
                                    out_data.rotated_x, out_data.rotated_y));
        end else begin
          want = expected_points.pop_front();
          if (out_data.rotated_x !== want.rotated_x)
            report_mismatch($sformatf("rotated_x expected %0d got %0d",
                                      want.rotated_x, out_data.rotated_x));
          if (out_data.rotated_y !== want.rotated_y)
            report_mismatch($sformatf("rotated_y expected %0d got %0d",
                                      want.rotated_y, out_data.rotated_y));
          if (out_data.saturated !== want.saturated)
            report_mismatch($sformatf("saturated expected %0b got %0b",
                                      want.saturated, out_data.saturated));
        end
      end
      if (in_valid && in_ready) begin
        expected_points.push_back(predict_rotation(regs, in_data));
      end
      if (cfg_we) begin
        case (cfg_index)
          prca_pkg::CFG_CENTER_X:    regs.center_x    = prca_pkg::prca_coord_t'(cfg_data);
          prca_pkg::CFG_CENTER_Y:    regs.center_y    = prca_pkg::prca_coord_t'(cfg_data);
          prca_pkg::CFG_ANGLE_TURNS: regs.angle_turns = cfg_data[prca_pkg::ANGLE_BITS-1:0];
          prca_pkg::CFG_CLOCKWISE:   regs.clockwise   = cfg_data[0];
          default: ;
        endcase
      end
    end
    points_pending = expected_points.size();
  end

endmodule

### tb/sv/point_rotate_about_center_tb.sv
// ----------------------------------------------------------------------------
// point_rotate_about_center_tb
// streams points through the rotator under a series of centers, angles and
// directions, with bursty input and a stalling receiver; a checker compares
// ----------------------------------------------------------------------------
module point_rotate_about_center_tb;

  localparam int     HALF_PERIOD   = 2;
  localparam int     RESET_CYCLES  = 11;
  localparam int     RANDOM_POINTS = 900;
  localparam int     SETTLE_CYCLES = 40;       // more than the pipeline depth
  localparam longint RUN_LIMIT     = 2000000;
  localparam logic [prca_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd6;  // no register behind it
  localparam prca_pkg::prca_coord_t C_MAX = prca_pkg::prca_coord_t'(prca_pkg::COORD_HI);
  localparam prca_pkg::prca_coord_t C_MIN = prca_pkg::prca_coord_t'(prca_pkg::COORD_LO);

  typedef enum {RX_OPEN, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_pattern_t;

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            cfg_we;
  logic [prca_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [prca_pkg::CFG_DW-1:0]     cfg_data;
  logic                            in_valid;
  logic                            in_ready;
  prca_pkg::prca_in_t              in_data;
  logic                            out_valid;
  logic                            out_ready;
  prca_pkg::prca_out_t             out_data;
  int                              mismatch_total;
  int                              points_pending;
  int                              burst_left;
  prca_pkg::prca_coord_t           cur_cx;
  prca_pkg::prca_coord_t           cur_cy;

  point_rotate_about_center uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  point_rotate_checker point_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .mismatch_count (mismatch_total),
    .points_pending (points_pending)
  );

  always #HALF_PERIOD clk = ~clk;

  initial begin
    #(RUN_LIMIT);
    $display("point_rotate_about_center_tb: done, errors");
    $finish;
  end

  // receiver stalls on its own pattern, a new one chosen at random when each run of it ends
  initial begin : receiver
    rx_pattern_t pattern;
    int          left;
    int          tick;
    out_ready = 1'b0;
    pattern   = RX_OPEN;
    left      = 0;
    tick      = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        pattern = rx_pattern_t'($urandom_range(0, 3));
        left    = $urandom_range(16, 128);
      end
      left--;
      tick++;
      case (pattern)
        RX_OPEN:     out_ready <= 1'b1;
        RX_COIN:     out_ready <= ($urandom_range(0, 1) == 1);
        RX_PERIODIC: out_ready <= ((tick % 5) != 0);
        default:     out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic write_reg(input logic [prca_pkg::CFG_IDX_W-1:0] idx,
                           input logic [prca_pkg::CFG_DW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // registers only change with nothing in flight
  task automatic drain_points();
    in_valid <= 1'b0;
    while (points_pending != 0) @(negedge clk);
  endtask

  task automatic retune(input prca_pkg::prca_coord_t cx, input prca_pkg::prca_coord_t cy,
                        input logic [prca_pkg::CFG_DW-1:0] angle_word,
                        input logic [prca_pkg::CFG_DW-1:0] cw_word);
    drain_points();
    write_reg(prca_pkg::CFG_CENTER_X, cx);
    write_reg(prca_pkg::CFG_CENTER_Y, cy);
    write_reg(prca_pkg::CFG_ANGLE_TURNS, angle_word);
    write_reg(prca_pkg::CFG_CLOCKWISE, cw_word);
    cur_cx = cx;
    cur_cy = cy;
  endtask

  task automatic idle_sender(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic push_point(input prca_pkg::prca_coord_t x, input prca_pkg::prca_coord_t y);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 10));
    end
    burst_left--;
    in_valid          <= 1'b1;
    in_data.point_x   <= x;
    in_data.point_y   <= y;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  function automatic prca_pkg::prca_coord_t extreme_coord();
    case ($urandom_range(0, 3))
      0:       return C_MAX;
      1:       return C_MIN;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  function automatic prca_pkg::prca_coord_t random_center();
    case ($urandom_range(0, 3))
      0:       return extreme_coord();
      1:       return prca_pkg::prca_coord_t'(int'($urandom_range(0, 2000)) - 1000);
      2:       return prca_pkg::prca_coord_t'($urandom);
      default: return '0;
    endcase
  endfunction

  function automatic prca_pkg::prca_in_t random_point(input prca_pkg::prca_coord_t cx,
                                                      input prca_pkg::prca_coord_t cy);
    prca_pkg::prca_in_t p;
    int                 pick;
    pick      = $urandom_range(0, 99);
    p.point_x = prca_pkg::prca_coord_t'($urandom);
    p.point_y = prca_pkg::prca_coord_t'($urandom);
    if (pick < 10) begin
      p.point_x = cx;
      p.point_y = cy;
    end else if (pick < 40) begin
      p.point_x = cx + prca_pkg::prca_coord_t'(int'($urandom_range(0, 600)) - 300);
      p.point_y = cy + prca_pkg::prca_coord_t'(int'($urandom_range(0, 600)) - 300);
    end else if (pick < 50) begin
      p.point_x = extreme_coord();
      p.point_y = extreme_coord();
    end else if (pick < 60) begin
      p.point_x = cx + prca_pkg::prca_coord_t'(int'($urandom_range(0, 2097152)) - 1048576);
      p.point_y = cy + prca_pkg::prca_coord_t'(int'($urandom_range(0, 2097152)) - 1048576);
    end
    return p;
  endfunction

  task automatic configure_random();
    logic [prca_pkg::CFG_DW-1:0]     angle_word;
    logic [prca_pkg::ANGLE_BITS-1:0] angle;
    angle = prca_pkg::ANGLE_BITS'($urandom);
    case ($urandom_range(0, 15))
      0:  angle = 16'h0000;
      1:  angle = prca_pkg::QUARTER;
      2:  angle = 16'h8000;
      3:  angle = 16'hC000;
      4:  angle = 16'h2000;
      5:  angle = 16'hE000;
      6:  angle = 16'hFFFF;
      7:  angle = 16'h0001;
      default: ;
    endcase
    // stray high bits above the angle field
    angle_word                               = prca_pkg::CFG_DW'($urandom);
    angle_word[prca_pkg::ANGLE_BITS-1:0]     = angle;
    retune(random_center(), random_center(), angle_word, prca_pkg::CFG_DW'($urandom));
    if ($urandom_range(0, 3) == 0) write_reg(CFG_UNMAPPED, prca_pkg::CFG_DW'($urandom));
  endtask

  initial begin : stimulus
    prca_pkg::prca_in_t p;
    int                 sent;
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    in_valid   = 1'b0;
    in_data    = '0;
    burst_left = 0;
    cur_cx     = '0;
    cur_cy     = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // reset settings: exact quarter turn clockwise about the origin
    push_point(24'sd0, 24'sd0);
    push_point(C_MAX, C_MIN);
    push_point(C_MIN, C_MAX);
    push_point(24'sd1, -24'sd1);

    // write to an index with no register, then counterclockwise with stray bits
    drain_points();
    write_reg(CFG_UNMAPPED, 24'h123456);
    write_reg(prca_pkg::CFG_CLOCKWISE, 24'hFFFFFE);
    push_point(C_MIN, C_MIN);
    push_point(24'sd5, 24'sd7);

    // half turn about an extreme corner, angle word with stray high bits
    retune(C_MAX, C_MIN, 24'hFF8000, 24'h000001);
    push_point(C_MAX, C_MIN);
    push_point(C_MIN, C_MAX);
    push_point(24'sd0, 24'sd0);
    push_point(C_MAX - 24'sd1, C_MIN + 24'sd1);

    // zero angle goes through the cordic path
    retune(-24'sd3, 24'sd2, 24'h000000, 24'h000000);
    push_point(C_MAX, C_MAX);
    push_point(C_MIN, C_MIN);
    push_point(-24'sd3, 24'sd3);

    retune(24'sd1000, -24'sd1000, 24'h00C000, 24'h000001);
    push_point(C_MIN, C_MAX);
    push_point(24'sd2000, 24'sd0);

    retune(24'sd0, 24'sd0, 24'h00FFFF, 24'h000000);
    push_point(C_MAX, 24'sd0);
    push_point(24'sd0, C_MIN);
    retune(24'sd0, 24'sd0, 24'h000001, 24'h000001);
    push_point(24'sd12345, -24'sd6789);

    // residual right at the eighth-turn boundary
    retune(24'sd0, 24'sd0, 24'h002000, 24'h000000);
    push_point(C_MAX, C_MAX);
    push_point(24'sd100, 24'sd0);
    retune(24'sd0, 24'sd0, 24'h006000, 24'h000001);
    push_point(24'sd100, 24'sd0);

    sent = 0;
    while (sent < RANDOM_POINTS) begin
      configure_random();
      repeat ($urandom_range(40, 110)) begin
        p = random_point(cur_cx, cur_cy);
        push_point(p.point_x, p.point_y);
        sent++;
      end
    end

    drain_points();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_total == 0 && points_pending == 0) begin
      $display("point_rotate_about_center_tb: done, clean");
    end else begin
      $display("point_rotate_about_center_tb: done, errors");
    end
    $finish;
  end

endmodule
